@@ rtl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, the controller state encoding, the command and status
// groups between controller and datapath, round constants and the
// SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_MARK,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;      // latch a new request from the input channel
    logic absorb;      // move pending bytes into the block buffer
    logic load_mark;   // queue the 0x80 pad byte as pending bytes
    logic zero_tail;   // clear the rest of the block buffer
    logic pad_len;     // clear the rest and place the bit length
    logic sched_load;  // copy block and chaining value into the round logic
    logic round;       // run one compression round
    logic chain_add;   // fold the working variables into the chaining value
    logic emit;        // hand the digest to the output buffer and restart
  } cmd_t;

  typedef struct packed {
    logic block_full;  // the current absorb step completes the block
    logic fill_over;   // block holds more than 56 bytes
    logic round_last;  // the current round is the last one
    logic msg_last;    // the latched request ends the message
    logic out_busy;    // output buffer still holds digest words
  } status_t;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [31:0] PAD_MARK = 32'h8000_0000;

  localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ rtl/sha256_stream_if.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream channels
// Valid/ready channels for message requests and digest words.
// ----------------------------------------------------------------------------
interface sha256_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        end_of_message;

  modport source (output valid, output data_word, output byte_count,
                  output end_of_message, input ready);
  modport sink (input valid, input data_word, input byte_count,
                input end_of_message, output ready);
endinterface

interface sha256_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

@@ rtl/sha256_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences request intake, byte absorption, padding, the 64 compression
// rounds and the digest handoff.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha256_pkg::status_t  status,
  output sha256_pkg::cmd_t     cmd
);

  sha256_pkg::state_t state, state_next;
  logic mark_done, mark_done_next;
  logic len_done, len_done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha256_pkg::ST_IDLE;
      mark_done <= 1'b0;
      len_done  <= 1'b0;
    end else begin
      state     <= state_next;
      mark_done <= mark_done_next;
      len_done  <= len_done_next;
    end
  end

  always_comb begin
    state_next     = state;
    mark_done_next = mark_done;
    len_done_next  = len_done;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      sha256_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sha256_pkg::ST_ABSORB;
        end
      end
      sha256_pkg::ST_ABSORB: begin
        cmd.absorb = 1'b1;
        if (status.block_full) begin
          state_next = sha256_pkg::ST_LOAD;
        end else if (!status.msg_last) begin
          state_next = sha256_pkg::ST_IDLE;
        end else if (!mark_done) begin
          state_next = sha256_pkg::ST_MARK;
        end else begin
          state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_MARK: begin
        cmd.load_mark  = 1'b1;
        mark_done_next = 1'b1;
        state_next     = sha256_pkg::ST_ABSORB;
      end
      sha256_pkg::ST_PAD: begin
        // With no room for the length, the tail block goes out without it.
        if (status.fill_over) begin
          cmd.zero_tail = 1'b1;
        end else begin
          cmd.pad_len   = 1'b1;
          len_done_next = 1'b1;
        end
        state_next = sha256_pkg::ST_LOAD;
      end
      sha256_pkg::ST_LOAD: begin
        cmd.sched_load = 1'b1;
        state_next     = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.round_last) begin
          state_next = sha256_pkg::ST_ADD;
        end
      end
      sha256_pkg::ST_ADD: begin
        cmd.chain_add = 1'b1;
        state_next    = len_done ? sha256_pkg::ST_FINISH : sha256_pkg::ST_ABSORB;
      end
      sha256_pkg::ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.emit       = 1'b1;
          mark_done_next = 1'b0;
          len_done_next  = 1'b0;
          state_next     = sha256_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sha256_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/sha256_dp.sv @@
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer with byte placement, message length, message schedule,
// round logic, chaining value and the digest output buffer.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sha256_pkg::cmd_t     cmd,
  output sha256_pkg::status_t  status,
  input  logic [31:0]          data_word,
  input  logic [2:0]           byte_count,
  input  logic                 end_of_message,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          digest_word,
  output logic [2:0]           word_index,
  output logic                 last_word
);

  // Request bytes not yet placed, left-aligned.
  logic [31:0] pend_word;
  logic [2:0]  pend_count;
  logic        msg_last;

  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [31:0] blk [sha256_pkg::BLOCK_WORDS];
  logic [31:0] blk_next [sha256_pkg::BLOCK_WORDS];

  logic [2:0]  clamp_count;
  logic [6:0]  room;
  logic [2:0]  take;
  logic [6:0]  fill_sum;

  logic [31:0] sched [sha256_pkg::BLOCK_WORDS];
  logic [31:0] sched_new;
  logic [5:0]  rnd;
  logic [31:0] wa, wb, wc, wd, we, wf, wg, wh;
  logic [31:0] t1, t2;
  logic [31:0] chain [sha256_pkg::DIGEST_WORDS];

  logic [31:0] obuf [sha256_pkg::DIGEST_WORDS];
  logic [2:0]  oidx;
  logic        obusy;

  assign clamp_count = (byte_count > 3'd4) ? 3'd4 : byte_count;
  assign room        = 7'd64 - {1'b0, fill};
  assign take        = ({4'b0, pend_count} < room) ? pend_count : room[2:0];
  assign fill_sum    = {1'b0, fill} + {4'b0, take};

  assign status.block_full = fill_sum[6];
  assign status.fill_over  = (fill > sha256_pkg::LEN_OFFSET);
  assign status.round_last = (rnd == 6'd63);
  assign status.msg_last   = msg_last;
  assign status.out_busy   = obusy;

  // Request intake and pending bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 3'd0;
      msg_last   <= 1'b0;
      msg_bits   <= 64'd0;
    end else begin
      if (cmd.accept) begin
        pend_word  <= data_word;
        pend_count <= clamp_count;
        msg_last   <= end_of_message;
        msg_bits   <= msg_bits + {58'd0, clamp_count, 3'b000};
      end else if (cmd.load_mark) begin
        pend_word  <= sha256_pkg::PAD_MARK;
        pend_count <= 3'd1;
      end else if (cmd.absorb) begin
        pend_word  <= pend_word << {take, 3'b000};
        pend_count <= pend_count - take;
      end else if (cmd.emit) begin
        msg_last <= 1'b0;
        msg_bits <= 64'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 6'd0;
    end else if (cmd.absorb) begin
      fill <= fill_sum[5:0];
    end else if (cmd.zero_tail || cmd.pad_len || cmd.emit) begin
      fill <= 6'd0;
    end
  end

  // Byte placement into the block buffer.
  always_comb begin
    logic [5:0] off;
    blk_next = blk;
    for (int p = 0; p < sha256_pkg::BLOCK_BYTES; p++) begin
      off = 6'(p) - fill;
      if (cmd.absorb && (off < {3'b0, take})) begin
        blk_next[p / 4][31 - 8 * (p % 4) -: 8] = pend_word[{2'd3 - off[1:0], 3'b000} +: 8];
      end else if ((cmd.zero_tail || cmd.pad_len) && (6'(p) >= fill)) begin
        blk_next[p / 4][31 - 8 * (p % 4) -: 8] = 8'h00;
      end
    end
    if (cmd.pad_len) begin
      blk_next[14] = msg_bits[63:32];
      blk_next[15] = msg_bits[31:0];
    end
  end

  always_ff @(posedge clk) begin
    blk <= blk_next;
  end

  // Message schedule as a sixteen-word shift line.
  assign sched_new = sched[0] + sha256_pkg::small_sigma0(sched[1]) + sched[9]
                   + sha256_pkg::small_sigma1(sched[14]);

  always_ff @(posedge clk) begin
    if (cmd.sched_load) begin
      sched <= blk;
    end else if (cmd.round) begin
      for (int i = 0; i < sha256_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha256_pkg::BLOCK_WORDS - 1] <= sched_new;
    end
  end

  assign t1 = wh + sha256_pkg::big_sigma1(we) + ((we & wf) ^ (~we & wg))
            + sha256_pkg::ROUND_K[rnd] + sched[0];
  assign t2 = sha256_pkg::big_sigma0(wa) + ((wa & wb) ^ (wa & wc) ^ (wb & wc));

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= 6'd0;
    end else if (cmd.sched_load) begin
      rnd <= 6'd0;
    end else if (cmd.round) begin
      rnd <= rnd + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched_load) begin
      wa <= chain[0]; wb <= chain[1]; wc <= chain[2]; wd <= chain[3];
      we <= chain[4]; wf <= chain[5]; wg <= chain[6]; wh <= chain[7];
    end else if (cmd.round) begin
      wh <= wg; wg <= wf; wf <= we; we <= wd + t1;
      wd <= wc; wc <= wb; wb <= wa; wa <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      chain <= sha256_pkg::INIT_HASH;
    end else if (cmd.chain_add) begin
      chain[0] <= chain[0] + wa; chain[1] <= chain[1] + wb;
      chain[2] <= chain[2] + wc; chain[3] <= chain[3] + wd;
      chain[4] <= chain[4] + we; chain[5] <= chain[5] + wf;
      chain[6] <= chain[6] + wg; chain[7] <= chain[7] + wh;
    end
  end

  // Digest output buffer; it drains on its own while the next message runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      obusy <= 1'b0;
      oidx  <= 3'd0;
    end else if (cmd.emit) begin
      obusy <= 1'b1;
      oidx  <= 3'd0;
    end else if (obusy && out_ready) begin
      oidx <= oidx + 3'd1;
      if (oidx == 3'd7) begin
        obusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      obuf <= chain;
    end else if (obusy && out_ready) begin
      for (int i = 0; i < sha256_pkg::DIGEST_WORDS - 1; i++) begin
        obuf[i] <= obuf[i + 1];
      end
    end
  end

  assign out_valid   = obusy;
  assign digest_word = obuf[0];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte message with SHA-256 and returns the digest as eight words.
//
// msg carries one request of up to four bytes, first byte in bits 31:24,
// with byte_count valid bytes (counts above four act as four) and
// end_of_message on the final request. digest returns eight 32-bit words,
// word_index 0 first, last_word set on the eighth.
// A non-final request that does not finish a 64-byte block is absorbed and the
// controller returns to idle. One that completes a block then loads the
// schedule, runs 64 rounds on one round unit, folds in the chaining value
// and places any bytes left over. The final request adds padding and one
// or two more compressions before the digest goes to the output buffer.
// After reset the chaining value holds the SHA-256 initial value and no
// bytes are buffered. Digest words sit in an output buffer, so a stalled
// receiver does not hold up the next message; only a second digest that
// finishes before the first has drained waits for the buffer.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic            clk,
  input  logic            rst,
  sha256_msg_if.sink      msg,
  sha256_digest_if.source digest
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;

  sha256_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg.valid),
    .in_ready (msg.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sha256_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .data_word      (msg.data_word),
    .byte_count     (msg.byte_count),
    .end_of_message (msg.end_of_message),
    .out_valid      (digest.valid),
    .out_ready      (digest.ready),
    .digest_word    (digest.digest_word),
    .word_index     (digest.word_index),
    .last_word      (digest.last_word)
  );

endmodule

@@ tb/tb_sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Sends byte messages as four-byte requests and checks every digest word
// against a SHA-256 computation kept inside the testbench. Known vectors
// come first. Random messages follow, with lengths around the padding
// boundary and with odd byte counts mixed in. Both channels stall at random
// until a final stretch runs at full rate.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [2:0] FULL_WORD = 3'd4;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst;

  sha256_msg_if    msg_ch ();
  sha256_digest_if digest_ch ();

  sha256_stream_hasher dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (digest_ch)
  );

  always #2 clk = ~clk;

  // Hash state of the message in flight, as the block should hold it.
  logic [31:0]  chain_h [8];
  logic [7:0]   block_buf [64];
  int unsigned  block_fill;
  logic [63:0]  msg_length_bits;
  digest_word_t pending_digest [$];

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  bit          no_idle = 1'b0;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
    for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    block_fill = 0;
    msg_length_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  function automatic void absorb_byte(input logic [7:0] value);
    block_buf[block_fill] = value;
    block_fill++;
    if (block_fill == 64) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // Folds one accepted request into the hash and, on the final request of a
  // message, queues the eight digest words that should come out.
  function automatic void hash_request(input logic [31:0] word, input logic [2:0] count,
                                       input logic eom);
    int unsigned nbytes;
    digest_word_t dw;
    nbytes = (count > FULL_WORD) ? 4 : count;
    for (int i = 0; i < nbytes; i++) absorb_byte(8'(word >> (24 - 8 * i)));
    msg_length_bits += 64'(nbytes * 8);
    if (eom) begin
      absorb_byte(8'h80);
      while (block_fill != 56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) block_buf[56 + i] = 8'(msg_length_bits >> (56 - 8 * i));
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.word = chain_h[i];
        dw.index = 3'(i);
        dw.last = (i == 7);
        pending_digest.insert(pending_digest.size(), dw);
      end
      restart_hash();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0d] %s: got %h, expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Called just after the clock rises; returns as soon as the DUT has taken the request.
  task automatic send_request(input logic [31:0] word, input logic [2:0] count,
                              input logic eom);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      msg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.data_word <= word;
    msg_ch.byte_count <= count;
    msg_ch.end_of_message <= eom;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    hash_request(word, count, eom);
    requests_sent++;
  endtask

  function automatic logic [31:0] random_data();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Most messages are well formed; about one body request in ten carries an
  // odd count, which the block absorbs as given (counts above four act as four).
  task automatic send_random_message();
    int body;
    int pick;
    logic [2:0] cnt;
    pick = $urandom_range(0, 9);
    if (pick < 6) body = $urandom_range(0, 12);
    else if (pick < 9) body = $urandom_range(13, 17);
    else body = $urandom_range(18, 40);
    for (int i = 0; i < body; i++) begin
      cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : FULL_WORD;
      send_request(random_data(), cnt, 1'b0);
    end
    send_request(random_data(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic test_known_vectors();
    // Empty message.
    send_request(32'h0000_0000, 3'd0, 1'b1);
    // "abc" in one short final request.
    send_request(32'h6162_6300, 3'd3, 1'b1);
    // Count above four on the final request.
    send_request(32'hffff_ffff, 3'd7, 1'b1);
    // Requests with counts other than four that are not final keep the message going.
    send_request(32'ha5c3_0f96, 3'd1, 1'b0);
    send_request(32'h1234_5678, 3'd2, 1'b0);
    send_request(32'hffff_ffff, 3'd6, 1'b0);
    send_request(32'h0000_0000, 3'd5, 1'b0);
    send_request(32'hdead_beef, FULL_WORD, 1'b1);
    send_request(32'hffff_ffff, 3'd3, 1'b0);
    send_request(32'h0000_0000, 3'd0, 1'b1);
    // 56 bytes: the pad does not fit, so a second block is needed.
    for (int i = 0; i < 14; i++) begin
      send_request((i % 2 == 0) ? 32'hffff_ffff : 32'h0000_0000, FULL_WORD, i == 13);
    end
  endtask

  task automatic test_random_messages(input int unsigned target);
    while (requests_sent < target) send_random_message();
  endtask

  task automatic test_streaming_messages(input int unsigned target);
    no_idle = 1'b1;
    while (requests_sent < target) send_random_message();
  endtask

  initial begin
    rst = 1'b1;
    msg_ch.valid = 1'b0;
    msg_ch.data_word = '0;
    msg_ch.byte_count = '0;
    msg_ch.end_of_message = 1'b0;
    restart_hash();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_vectors();
    test_random_messages(300);
    test_streaming_messages(365);
    msg_ch.valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("sha256_stream_hasher: match");
    end else begin
      $display("sha256_stream_hasher: mismatch");
    end
    $finish;
  end

  // Receiver: random stall bursts until the final stretch.
  initial begin
    digest_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        digest_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      digest_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && digest_ch.valid && digest_ch.ready) begin
      if (pending_digest.size() == 0) begin
        report_mismatch("unexpected digest word", digest_ch.digest_word, '0);
      end else begin
        want = pending_digest.pop_front();
        if (digest_ch.digest_word !== want.word)
          report_mismatch("digest_word", digest_ch.digest_word, want.word);
        if (digest_ch.word_index !== want.index)
          report_mismatch("word_index", 32'(digest_ch.word_index), 32'(want.index));
        if (digest_ch.last_word !== want.last)
          report_mismatch("last_word", 32'(digest_ch.last_word), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0d] timeout, %0d digest words outstanding", cycle_count,
               pending_digest.size());
      $display("sha256_stream_hasher: mismatch");
      $finish;
    end
  end

endmodule
